[src/fbf_pkg.sv]
// Shared types, constants and helpers for the framebuffer flush unit.
// Depends on nothing; every other file in src imports it.
package fbf_pkg;

    // Default geometry of the pixel store
    localparam int DEF_MAX_COLS = 320;
    localparam int DEF_MAX_ROWS = 240;

    // Width that holds any frame dimension up to 1024
    localparam int DIM_W = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 1'd1;
    localparam logic [8:0] RST_ACTIVE_WIDTH  = 9'd320;
    localparam logic [7:0] RST_ACTIVE_HEIGHT = 8'd240;

    // Input item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_FLUSH = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Display controller commands
    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_PASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;

    // Header sequence positions
    localparam logic [3:0] HDR_CASET  = 4'd0;
    localparam logic [3:0] HDR_COL_HI = 4'd3;
    localparam logic [3:0] HDR_COL_LO = 4'd4;
    localparam logic [3:0] HDR_PASET  = 4'd5;
    localparam logic [3:0] HDR_ROW_HI = 4'd8;
    localparam logic [3:0] HDR_ROW_LO = 4'd9;
    localparam logic [3:0] HDR_RAMWR  = 4'd10;
    localparam logic [3:0] HDR_LEN    = 4'd11;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_FLUSH,
        OP_TICK
    } op_kind_t;

    // One operation handed from the front to the back
    typedef struct packed {
        op_kind_t         kind;
        logic [15:0]      pixel;
        logic [DIM_W-1:0] frame_w;
        logic [DIM_W-1:0] frame_h;
    } op_t;

    // Status from the back to the front
    typedef struct packed {
        logic clear_busy;
    } back_status_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ
    } back_state_t;

    typedef struct packed {
        logic [7:0] value;
        logic       is_data;
    } hdr_byte_t;

    // Byte of the window header at a given position
    function automatic hdr_byte_t hdr_byte(input logic [3:0] step,
                                           input logic [DIM_W-1:0] w1,
                                           input logic [DIM_W-1:0] h1);
        hdr_byte_t r;
        r.is_data = 1'b1;
        case (step)
            HDR_CASET: begin
                r.value   = CMD_CASET;
                r.is_data = 1'b0;
            end
            HDR_COL_HI: r.value = 8'(w1 >> 8);
            HDR_COL_LO: r.value = w1[7:0];
            HDR_PASET: begin
                r.value   = CMD_PASET;
                r.is_data = 1'b0;
            end
            HDR_ROW_HI: r.value = 8'(h1 >> 8);
            HDR_ROW_LO: r.value = h1[7:0];
            HDR_RAMWR: begin
                r.value   = CMD_RAMWR;
                r.is_data = 1'b0;
            end
            default: r.value = 8'h00;
        endcase
        return r;
    endfunction

    // 24-bit colour reduced to RGB565
    function automatic logic [15:0] to_rgb565(input logic [23:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

[src/fbf_front.sv]
// Front end: configuration registers, item classification, clipping and
// colour conversion. Depends on fbf_pkg.
module fbf_front #(
    parameter int MAX_COLS = 320,
    parameter int MAX_ROWS = 240,
    parameter int ADDR_W   = 17
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic signed [15:0]            s_pos_x,
    input  logic signed [15:0]            s_pos_y,
    input  logic [23:0]                   s_colour,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbf_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                          op_valid,
    input  logic                          op_ready,
    output fbf_pkg::op_t                  op,
    output logic [ADDR_W-1:0]             op_addr,
    input  fbf_pkg::back_status_t         status
);
    import fbf_pkg::*;

    logic [8:0]       active_width_reg;
    logic [7:0]       active_height_reg;
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic [DIM_W-1:0] aw_ext;
    logic [DIM_W-1:0] ah_ext;
    logic             inside_window;
    logic             keep;

    // Configuration registers take a write in any cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_width_reg  <= RST_ACTIVE_WIDTH;
            active_height_reg <= RST_ACTIVE_HEIGHT;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_ACTIVE_WIDTH) begin
                active_width_reg <= cfg_data[8:0];
            end else if (cfg_index == CFG_ACTIVE_HEIGHT) begin
                active_height_reg <= cfg_data[7:0];
            end
        end
    end

    // Effective frame size, clamped between one and the store's geometry
    always_comb begin
        aw_ext = DIM_W'(active_width_reg);
        ah_ext = DIM_W'(active_height_reg);
        if (aw_ext == '0) begin
            eff_w = DIM_W'(1);
        end else if (aw_ext > DIM_W'(MAX_COLS)) begin
            eff_w = DIM_W'(MAX_COLS);
        end else begin
            eff_w = aw_ext;
        end
        if (ah_ext == '0) begin
            eff_h = DIM_W'(1);
        end else if (ah_ext > DIM_W'(MAX_ROWS)) begin
            eff_h = DIM_W'(MAX_ROWS);
        end else begin
            eff_h = ah_ext;
        end
    end

    // Clipping: negative coordinates and those past the window are dropped
    assign inside_window = !s_pos_x[15] && !s_pos_y[15]
                        && ({1'b0, s_pos_x[14:0]} < 16'(eff_w))
                        && ({1'b0, s_pos_y[14:0]} < 16'(eff_h));

    // Store address is row times the store pitch plus column
    assign op_addr = ADDR_W'(ADDR_W'(s_pos_y[14:0]) * ADDR_W'(MAX_COLS))
                   + ADDR_W'(s_pos_x[14:0]);

    // Classify the item; dropped writes and unused modes never reach the back
    always_comb begin
        op.pixel   = to_rgb565(s_colour);
        op.frame_w = eff_w;
        op.frame_h = eff_h;
        keep       = 1'b0;
        op.kind    = OP_TICK;
        case (s_mode)
            MODE_WRITE: begin
                op.kind = OP_WRITE;
                keep    = inside_window;
            end
            MODE_FLUSH: begin
                op.kind = OP_FLUSH;
                keep    = 1'b1;
            end
            MODE_TICK: begin
                op.kind = OP_TICK;
                keep    = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    // Items are taken only once the store has been cleared
    assign s_ready  = op_ready && !status.clear_busy;
    assign op_valid = s_valid && s_ready && keep;

endmodule

[src/fbf_queue.sv]
// Short FIFO that separates the front end from the back end.
// Depends on fbf_pkg, which gives the depth the top level sets.
module fbf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    import fbf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Payload slots
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers wrap at the depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // The count never exceeds the depth, a full queue takes no write, and an empty queue has equal pointers
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CNT_W'(DEPTH)) && !pop |=> (count_reg == CNT_W'(DEPTH)))
        else $error("full queue lost an entry");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

[src/fbf_back.sv]
// Back end: pixel store with its clearing pass, flush sequencer and the
// output register. Depends on fbf_pkg.
module fbf_back #(
    parameter int MAX_COLS = 320,
    parameter int MAX_ROWS = 240,
    parameter int ADDR_W   = 17
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  op_valid,
    output logic                  op_ready,
    input  fbf_pkg::op_t          op,
    input  logic [ADDR_W-1:0]     op_addr,
    output fbf_pkg::back_status_t status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_is_data,
    output logic                  m_release_select,
    output logic                  m_frame_last
);
    import fbf_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;

    logic [15:0] store_mem [DEPTH];
    logic [15:0] rd_data_reg;

    back_state_t      state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic             active_reg, active_next;
    logic [3:0]       step_reg, step_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic             low_reg, low_next;
    logic [DIM_W-1:0] fw_reg, fw_next;
    logic [DIM_W-1:0] fh_reg, fh_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             is_data_reg, is_data_next;
    logic             release_reg, release_next;
    logic             last_reg, last_next;

    logic             out_free;
    logic             pop;
    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]      mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic             col_end;
    logic             row_end;
    hdr_byte_t        hdr;

    assign out_free = !m_valid_reg || m_ready;
    assign col_end  = (col_reg == fw_reg - 1'b1);
    assign row_end  = (row_reg == fh_reg - 1'b1);
    assign hdr      = hdr_byte(step_reg, fw_reg - 1'b1, fh_reg - 1'b1);

    // An operation is taken in the idle state; ticks wait for a free output
    assign op_ready = (state_reg == BK_IDLE) && (op.kind != OP_TICK || out_free);
    assign pop      = op_valid && op_ready;

    assign status.clear_busy = (state_reg == BK_CLEAR);

    // Pixel store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= store_mem[mem_raddr];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (pop && op.kind == OP_TICK && active_reg && step_reg == HDR_LEN) begin
                    state_next = BK_READ;
                end
            end
            BK_READ: state_next = BK_IDLE;
            default: state_next = BK_CLEAR;
        endcase
    end

    // Datapath and sequencer updates
    always_comb begin
        clr_addr_next = clr_addr_reg;
        active_next   = active_reg;
        step_next     = step_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        low_next      = low_reg;
        fw_next       = fw_reg;
        fh_next       = fh_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        byte_next     = byte_reg;
        is_data_next  = is_data_reg;
        release_next  = release_reg;
        last_next     = last_reg;
        mem_we        = 1'b0;
        mem_waddr     = op_addr;
        mem_wdata     = op.pixel;
        mem_raddr     = row_base_reg + ADDR_W'(col_reg);
        case (state_reg)
            BK_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            BK_IDLE: begin
                if (pop) begin
                    case (op.kind)
                        OP_WRITE: mem_we = 1'b1;
                        OP_FLUSH: begin
                            // A request during a frame is ignored
                            if (!active_reg) begin
                                active_next   = 1'b1;
                                step_next     = '0;
                                col_next      = '0;
                                row_next      = '0;
                                row_base_next = '0;
                                low_next      = 1'b0;
                                fw_next       = op.frame_w;
                                fh_next       = op.frame_h;
                            end
                        end
                        OP_TICK: begin
                            // Header bytes come straight from the sequencer
                            if (active_reg && step_reg != HDR_LEN) begin
                                m_valid_next = 1'b1;
                                byte_next    = hdr.value;
                                is_data_next = hdr.is_data;
                                release_next = (step_reg != HDR_RAMWR);
                                last_next    = 1'b0;
                                step_next    = step_reg + 1'b1;
                            end
                        end
                        default: mem_we = 1'b0;
                    endcase
                end
            end
            BK_READ: begin
                // Pixel byte from the store read issued in the previous cycle
                m_valid_next = 1'b1;
                is_data_next = 1'b1;
                if (!low_reg) begin
                    byte_next    = rd_data_reg[15:8];
                    release_next = 1'b0;
                    last_next    = 1'b0;
                    low_next     = 1'b1;
                end else begin
                    byte_next    = rd_data_reg[7:0];
                    release_next = col_end && row_end;
                    last_next    = col_end && row_end;
                    low_next     = 1'b0;
                    if (col_end && row_end) begin
                        active_next   = 1'b0;
                        step_next     = '0;
                        col_next      = '0;
                        row_next      = '0;
                        row_base_next = '0;
                    end else if (col_end) begin
                        col_next      = '0;
                        row_next      = row_reg + 1'b1;
                        row_base_next = row_base_reg + ADDR_W'(MAX_COLS);
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            default: mem_we = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_CLEAR;
            clr_addr_reg <= '0;
            active_reg   <= 1'b0;
            step_reg     <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
            low_reg      <= 1'b0;
            fw_reg       <= DIM_W'(1);
            fh_reg       <= DIM_W'(1);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            active_reg   <= active_next;
            step_reg     <= step_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
            low_reg      <= low_next;
            fw_reg       <= fw_next;
            fh_reg       <= fh_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        is_data_reg <= is_data_next;
        release_reg <= release_next;
        last_reg    <= last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = byte_reg;
    assign m_is_data        = is_data_reg;
    assign m_release_select = release_reg;
    assign m_frame_last     = last_reg;

    // No operation is taken while the store is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_CLEAR) |-> !pop)
        else $error("operation taken during clearing pass");
    // A store read always returns to idle with a byte on the output in the cycle after
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_READ) |=> (state_reg == BK_IDLE) && m_valid_reg)
        else $error("pixel read did not produce a byte");
    // The header position never runs past the end of the header
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= HDR_LEN)
        else $error("header position out of range");
    // The final byte of a frame releases chip select; the frame must end with it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_READ) && low_reg && col_end && row_end |=> !active_reg)
        else $error("frame did not end on its last byte");

endmodule

[src/framebuffer_rgb565_flush_unit.sv]
// RGB565 framebuffer top level. Each accepted item passes the front end and the
// queue to the back end, whose output register holds each byte; a pixel byte
// first passes the registered store read, and a stalled output holds bytes back.
// Throughput: 1 item per cycle while the output is not stalled; a pixel tick
// holds the back end for its store read before the next item. Reset: a clearing
// pass writes black to all MAX_COLS*MAX_ROWS entries before any item is taken.
module framebuffer_rgb565_flush_unit #(
    parameter int MAX_COLS = fbf_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = fbf_pkg::DEF_MAX_ROWS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_mode,
    input  logic signed [15:0]             s_pos_x,
    input  logic signed [15:0]             s_pos_y,
    input  logic [23:0]                    s_colour,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_out_byte,
    output logic                           m_is_data,
    output logic                           m_release_select,
    output logic                           m_frame_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fbf_pkg::*;

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int Q_W    = $bits(op_t) + ADDR_W;

    op_t               fr_op;
    logic [ADDR_W-1:0] fr_addr;
    logic              fr_valid;
    logic              fr_ready;
    op_t               bk_op;
    logic [ADDR_W-1:0] bk_addr;
    logic              bk_valid;
    logic              bk_ready;
    back_status_t      status;

    fbf_front #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS),
        .ADDR_W  (ADDR_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_mode   (s_mode),
        .s_pos_x  (s_pos_x),
        .s_pos_y  (s_pos_y),
        .s_colour (s_colour),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .op_valid (fr_valid),
        .op_ready (fr_ready),
        .op       (fr_op),
        .op_addr  (fr_addr),
        .status   (status)
    );

    fbf_queue #(
        .WIDTH(Q_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(fr_valid),
        .wr_ready(fr_ready),
        .wr_data ({fr_op, fr_addr}),
        .rd_valid(bk_valid),
        .rd_ready(bk_ready),
        .rd_data ({bk_op, bk_addr})
    );

    fbf_back #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS),
        .ADDR_W  (ADDR_W)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .op_valid        (bk_valid),
        .op_ready        (bk_ready),
        .op              (bk_op),
        .op_addr         (bk_addr),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_is_data       (m_is_data),
        .m_release_select(m_release_select),
        .m_frame_last    (m_frame_last)
    );

endmodule
